// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the rail change trigger.
// Each check is sampled at the rising edge of i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check: when cond holds, prop must hold at the same edge.
`define RCFST_ASSERT_IMPL(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle check: when cond holds, prop must hold at the following edge.
`define RCFST_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: src/rcfst_pkg.sv
// Shared types and constants for the rail change trigger.
// No dependencies; every other module imports this package.
package rcfst_pkg;

    localparam int IN_CHAN_W   = 4;
    localparam int IN_SAMPLE_W = 10;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;

    localparam int CPM_W  = 10;
    localparam int RUNS_W = 4;
    localparam int HOLD_W = 8;
    localparam int RUN_W  = 4;

    localparam logic [RUN_W-1:0] RUN_MAX   = 4'd15;
    localparam logic [CPM_W-1:0] PER_MILLE = 10'd1000;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CPM_W-1:0]  CPM_RESET  = 10'd10;
    localparam logic [RUNS_W-1:0] RUNS_RESET = 4'd2;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANGE_PER_MILLE = 2'd0,
        CFG_RUNS_NEEDED      = 2'd1,
        CFG_FAST_HOLD_SWEEPS = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [CPM_W-1:0]  change_per_mille;
        logic [RUNS_W-1:0] runs_needed;
        logic [HOLD_W-1:0] fast_hold_sweeps;
    } t_cfg;

    typedef struct packed {
        logic fire;
        logic alarm;
        logic sweep_end;
    } t_sweep_req;

endpackage

// File: src/rcfst_cfg_regs.sv
// Configuration register bank of the rail change trigger.
// Depends on rcfst_pkg for register codes, widths and reset values.
module rcfst_cfg_regs
    import rcfst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_CHANGE_PER_MILLE: n_cfg.change_per_mille = i_cfg_data[CPM_W-1:0];
                CFG_RUNS_NEEDED:      n_cfg.runs_needed      = i_cfg_data[RUNS_W-1:0];
                CFG_FAST_HOLD_SWEEPS: n_cfg.fast_hold_sweeps = i_cfg_data[HOLD_W-1:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.change_per_mille <= CPM_RESET;
            r_cfg.runs_needed      <= RUNS_RESET;
            r_cfg.fast_hold_sweeps <= HOLD_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: src/rcfst_rail_state.sv
// Per-rail history memory and change test of the rail change trigger.
// Depends on rcfst_pkg; holds last code and run count per rail, plus usable flags.
module rcfst_rail_state
    import rcfst_pkg::*;
#(
    parameter int RAIL_COUNT  = 16,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // read port, used when a request is taken into the work register
    input  logic                   i_rd_en,
    input  logic [IN_CHAN_W-1:0]   i_rd_chan,
    // work register contents, committed when i_fire is high
    input  logic                   i_fire,
    input  logic [IN_CHAN_W-1:0]   i_chan,
    input  logic [IN_SAMPLE_W-1:0] i_sample,
    input  logic                   i_ok,
    input  t_cfg                   i_cfg,
    output logic                   o_alarm
);

    localparam int IDX_W  = (RAIL_COUNT > 1) ? $clog2(RAIL_COUNT) : 1;
    localparam int WORD_W = SAMPLE_BITS + RUN_W;
    localparam int EXT_W  = (SAMPLE_BITS > IN_SAMPLE_W) ? SAMPLE_BITS : IN_SAMPLE_W;
    localparam int PROD_W = SAMPLE_BITS + CPM_W;

    logic [WORD_W-1:0]     r_mem [RAIL_COUNT];
    logic [WORD_W-1:0]     r_rd_word;
    logic [RAIL_COUNT-1:0] r_have;

    logic [IDX_W-1:0]       w_idx;
    logic [IDX_W-1:0]       w_rd_idx;
    logic                   w_in_range;
    logic [EXT_W-1:0]       w_ext;
    logic [SAMPLE_BITS-1:0] w_code;
    logic [SAMPLE_BITS-1:0] w_last;
    logic [RUN_W-1:0]       w_run;
    logic [RUN_W-1:0]       w_run_inc;
    logic [SAMPLE_BITS-1:0] w_diff;
    logic [PROD_W-1:0]      w_lhs;
    logic [PROD_W-1:0]      w_rhs;
    logic                   w_usable;
    logic                   w_big;
    logic                   w_wr_en;
    logic [WORD_W-1:0]      w_wr_word;

    assign w_idx      = IDX_W'(i_chan);
    assign w_rd_idx   = IDX_W'(i_rd_chan);
    assign w_in_range = (32'(i_chan) < RAIL_COUNT);
    assign w_ext      = EXT_W'(i_sample);
    assign w_code     = w_ext[SAMPLE_BITS-1:0];

    assign w_last = r_rd_word[WORD_W-1:RUN_W];
    assign w_run  = r_rd_word[RUN_W-1:0];

    always_comb begin
        w_usable  = w_in_range && r_have[w_idx] && (w_last != '0);
        w_diff    = (w_code >= w_last) ? (w_code - w_last) : (w_last - w_code);
        w_lhs     = PROD_W'(w_diff) * PROD_W'(PER_MILLE);
        w_rhs     = PROD_W'(i_cfg.change_per_mille) * PROD_W'(w_last);
        w_big     = w_usable && (w_lhs > w_rhs);
        // saturate the run count at its top value
        w_run_inc = (w_run == RUN_MAX) ? w_run : (w_run + 1'b1);
        o_alarm   = i_ok && w_big && (w_run_inc >= i_cfg.runs_needed);
        w_wr_en   = i_fire && w_in_range && i_ok;
        w_wr_word = {w_code, (w_big ? w_run_inc : RUN_W'(0))};
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_idx] <= w_wr_word;
        end
    end

    // forward the word being written when the next request hits the same rail
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (w_wr_en && (w_idx == w_rd_idx)) begin
                r_rd_word <= w_wr_word;
            end else begin
                r_rd_word <= r_mem[w_rd_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= '0;
        end else if (i_fire && w_in_range) begin
            r_have[w_idx] <= i_ok;
        end
    end

endmodule

// File: src/rcfst_sweep_ctrl.sv
// Sweep flag, fast-mode latch and hold counter of the rail change trigger.
// Depends on rcfst_pkg for the config and sweep request structs.
module rcfst_sweep_ctrl
    import rcfst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_sweep_req i_req,
    input  t_cfg       i_cfg,
    output logic       o_fast_next
);

    logic              r_want;
    logic              r_fast;
    logic [HOLD_W-1:0] r_hold;
    logic              n_want;
    logic              n_fast;
    logic [HOLD_W-1:0] n_hold;
    logic              w_want_now;

    always_comb begin
        w_want_now = r_want || i_req.alarm;
        n_want     = w_want_now;
        n_fast     = r_fast;
        n_hold     = r_hold;
        if (i_req.sweep_end) begin
            if (w_want_now) begin
                n_fast = 1'b1;
                n_hold = i_cfg.fast_hold_sweeps;
            end else if (r_fast) begin
                if (r_hold != '0) begin
                    n_hold = r_hold - 1'b1;
                end
                if (n_hold == '0) begin
                    n_fast = 1'b0;
                end
            end
            n_want = 1'b0;
        end
    end

    assign o_fast_next = n_fast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_want <= 1'b0;
            r_fast <= 1'b0;
            r_hold <= '0;
        end else if (i_req.fire) begin
            r_want <= n_want;
            r_fast <= n_fast;
            r_hold <= n_hold;
        end
    end

endmodule

// File: src/rail_change_fast_sample_trigger_unit.sv
// Rail change trigger for fast sampling: top level with stream handshake and result register.
// Depends on rcfst_pkg, assert_macros.svh, rcfst_cfg_regs, rcfst_rail_state, rcfst_sweep_ctrl.
//
// Usage:
//   s_axis carries one converter sample per request: tdata holds channel and raw
//   code, tuser the sample-valid flag, tlast marks the last rail of a sweep.
//   m_axis returns one result per request: rail alarm and fast-mode state.
//   The cfg channel writes change_per_mille (0), runs_needed (1) and
//   fast_hold_sweeps (2); it is always ready and must be written only while idle; the block does not enforce this.
// Timing:
//   One request per cycle sustained while m_axis_tready stays high. A request taken sits in
//   the work register until it advances into its result register, whose contents show
//   on m_axis.
//   The per-rail memory read is registered at acceptance and the write-back of the
//   previous request is forwarded, so same-rail requests may follow back to back.
// Reset (i_rst_n low, synchronous): registers go to defaults, all rail histories are
//   marked unusable, fast mode and the hold counter clear; no clearing pass.
// Stall: when m_axis_tready is low the result holds, the work register holds one more
//   request, and s_axis_tready drops once both are full.
module rail_change_fast_sample_trigger_unit
    import rcfst_pkg::*;
#(
    parameter int RAIL_COUNT  = 16,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [3:0] channel, [13:4] sample, [15:14] zero
    input  logic                  s_axis_tuser,  // [0] sample_ok
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // [0] rail_alarm, [1] fast_mode, [7:2] zero
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    t_cfg       w_cfg;
    t_sweep_req w_req;

    logic                   r_in_valid;
    logic [IN_CHAN_W-1:0]   r_in_chan;
    logic [IN_SAMPLE_W-1:0] r_in_sample;
    logic                   r_in_ok;
    logic                   r_in_end;
    logic                   r_out_valid;
    logic                   r_out_alarm;
    logic                   r_out_fast;

    logic w_acc;
    logic w_adv;
    logic w_alarm;
    logic w_fast_next;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    assign w_req.fire      = w_adv;
    assign w_req.alarm     = w_alarm;
    assign w_req.sweep_end = r_in_end;

    rcfst_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    rcfst_rail_state #(
        .RAIL_COUNT  (RAIL_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rail (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_acc),
        .i_rd_chan (s_axis_tdata[IN_CHAN_W-1:0]),
        .i_fire    (w_adv),
        .i_chan    (r_in_chan),
        .i_sample  (r_in_sample),
        .i_ok      (r_in_ok),
        .i_cfg     (w_cfg),
        .o_alarm   (w_alarm)
    );

    rcfst_sweep_ctrl u_sweep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_cfg       (w_cfg),
        .o_fast_next (w_fast_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_in_chan   <= s_axis_tdata[IN_CHAN_W-1:0];
            r_in_sample <= s_axis_tdata[IN_CHAN_W +: IN_SAMPLE_W];
            r_in_ok     <= s_axis_tuser;
            r_in_end    <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_alarm <= w_alarm;
            r_out_fast  <= w_fast_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W-2)'(0), r_out_fast, r_out_alarm};

    `RCFST_ASSERT_IMPL(a_acc_has_room, w_acc, (!r_in_valid || w_adv), "work register overrun")
    `RCFST_ASSERT_IMPL(a_alarm_needs_ok, (w_adv && w_alarm), r_in_ok, "alarm on invalid sample")
    `RCFST_ASSERT_IMPL(a_alarm_end_fast, w_adv && w_alarm && r_in_end, w_fast_next, "no fast mode")
    `RCFST_ASSERT_NEXT(a_adv_shows_result, w_adv, m_axis_tvalid, "result not shown")

endmodule
